// ===== hdl/awn_pkg.sv =====
// Shared types, constants and register codes of the affine warp unit.
// No dependencies; every other file of the block but awn_stream_if imports this package.
package awn_pkg;

	localparam int DIM_W          = 9;
	localparam int POS_W          = 18;
	localparam int PIX_W          = 24;
	localparam int COEF_W         = 16;
	localparam int SHIFT_W        = 13;
	localparam int INV_W          = 32;
	localparam int APB_AW         = 5;
	localparam int APB_DW         = 32;
	localparam int QUEUE_DEPTH    = 4;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef enum logic [2:0] {
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C,
		REG_COEF_D,
		REG_SHIFT_X,
		REG_SHIFT_Y,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef enum logic [2:0] {
		INV_IDLE,
		INV_MUL,
		INV_DET,
		INV_LOAD,
		INV_DIV,
		INV_STORE
	} inv_state_t;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_blue;
		logic [7:0] pixel_green;
		logic [7:0] pixel_red;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_column;
		logic [7:0] out_row;
		logic       mapped;
		logic       singular;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pix;
		logic [POS_W-1:0] pos;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             last;
	} q_item_t;

	typedef struct packed {
		logic start;
	} inv_ctrl_t;

	typedef struct packed {
		logic                       ready;
		logic                       busy;
		logic                       singular;
		logic [3:0][INV_W-1:0]      coef;
	} inv_stat_t;

endpackage

// ===== hdl/awn_stream_if.sv =====
// Valid/ready channel carrying one word of a configurable payload type.
// Depends on nothing; payload types come from awn_pkg at instantiation.
interface awn_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/awn_inverse.sv =====
// Sequential 2x2 matrix inverse: determinant, then four restoring divisions.
// Depends on awn_pkg.
module awn_inverse (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [awn_pkg::COEF_W-1:0] coef_a,
	input  logic signed [awn_pkg::COEF_W-1:0] coef_b,
	input  logic signed [awn_pkg::COEF_W-1:0] coef_c,
	input  logic signed [awn_pkg::COEF_W-1:0] coef_d,
	input  logic                              clr,
	input  awn_pkg::inv_ctrl_t                ctrl,
	output awn_pkg::inv_stat_t                stat
);
	import awn_pkg::*;

	localparam int DVD_W     = 45;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	inv_state_t state_q, state_n;

	logic signed [2*COEF_W-1:0] pad_q, pbc_q;
	logic signed [2*COEF_W:0]   det_n;
	logic [2*COEF_W-1:0]        absdet_q;
	logic                       dneg_q, qneg_q;
	logic [DVD_W-1:0]           dvd_q;
	logic [2*COEF_W+1:0]        rem_q, trial, divisor;
	logic                       ge;
	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 k_q;
	logic                       ready_q, singular_q;
	logic [3:0][INV_W-1:0]      coef_q;
	logic signed [COEF_W-1:0]   nsel;
	logic                       nflip, nsign;
	logic [COEF_W-1:0]          nmag;
	logic [INV_W-1:0]           sat;

	always_comb begin
		det_n   = (2*COEF_W+1)'(pad_q) - (2*COEF_W+1)'(pbc_q);
		divisor = {1'b0, absdet_q, 1'b0};
		trial   = {rem_q[2*COEF_W:0], dvd_q[DVD_W-1]};
		ge      = trial >= divisor;
		case (k_q)
			2'd0: begin nsel = coef_d; nflip = 1'b0; end
			2'd1: begin nsel = coef_b; nflip = 1'b1; end
			2'd2: begin nsel = coef_c; nflip = 1'b1; end
			default: begin nsel = coef_a; nflip = 1'b0; end
		endcase
		nmag  = nsel[COEF_W-1] ? COEF_W'(-nsel) : nsel;
		nsign = nflip ? (nsel != '0 && !nsel[COEF_W-1]) : nsel[COEF_W-1];
		if (qneg_q) begin
			sat = (dvd_q > DVD_W'(64'h8000_0000)) ? 32'h8000_0000 : -dvd_q[INV_W-1:0];
		end else begin
			sat = (dvd_q > DVD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dvd_q[INV_W-1:0];
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			INV_IDLE:  if (ctrl.start) state_n = INV_MUL;
			INV_MUL:   state_n = INV_DET;
			INV_DET:   state_n = (det_n == '0) ? INV_IDLE : INV_LOAD;
			INV_LOAD:  state_n = INV_DIV;
			INV_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_n = INV_STORE;
			INV_STORE: state_n = (k_q == 2'd3) ? INV_IDLE : INV_LOAD;
			default:   state_n = INV_IDLE;
		endcase
	end

	always_comb begin
		stat.busy     = state_q != INV_IDLE;
		stat.ready    = ready_q;
		stat.singular = singular_q;
		stat.coef     = coef_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= INV_IDLE;
			ready_q    <= 1'b0;
			singular_q <= 1'b0;
			coef_q     <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				INV_DET: begin
					if (det_n == '0) begin
						singular_q <= 1'b1;
						coef_q     <= '0;
						ready_q    <= 1'b1;
					end else begin
						singular_q <= 1'b0;
					end
					k_q <= '0;
				end
				INV_LOAD: cnt_q <= '0;
				INV_DIV:  cnt_q <= cnt_q + 1'b1;
				INV_STORE: begin
					coef_q[k_q] <= sat;
					k_q         <= k_q + 1'b1;
					if (k_q == 2'd3) ready_q <= 1'b1;
				end
				default: ;
			endcase
			if (clr) ready_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			INV_MUL: begin
				pad_q <= coef_a * coef_d;
				pbc_q <= coef_b * coef_c;
			end
			INV_DET: begin
				absdet_q <= det_n[2*COEF_W] ? (2*COEF_W)'(-det_n) : det_n[2*COEF_W-1:0];
				dneg_q   <= det_n[2*COEF_W];
			end
			INV_LOAD: begin
				dvd_q  <= {nmag, 29'b0} + DVD_W'(absdet_q);
				rem_q  <= '0;
				qneg_q <= nsign ^ dneg_q;
			end
			INV_DIV: begin
				rem_q <= ge ? trial - divisor : trial;
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/awn_front.sv =====
// Front end: takes input words, assigns store and raster positions, and
// queues classified items. Depends on awn_pkg and awn_stream_if.
module awn_front (
	input  logic                             clk,
	input  logic                             arst_n,
	awn_stream_if.sink                       in_s,
	awn_stream_if.source                     q_s,
	input  logic [awn_pkg::DIM_W-1:0]        width,
	input  logic [awn_pkg::DIM_W-1:0]        height,
	input  logic [awn_pkg::POS_W-1:0]        size,
	input  logic                             restart
);
	import awn_pkg::*;

	localparam int CNT_W = $clog2(POS_W);

	logic [POS_W-1:0] ld_pos_q, em_pos_q, ld_p, dvd_q, quo_n;
	logic [DIM_W-1:0] em_col_q, em_row_q, rem_q, rem_n;
	logic [DIM_W:0]   trial;
	logic             ge, div_busy_q, em_last, accept;
	logic [CNT_W-1:0] cnt_q;
	q_item_t          item;
	in_word_t         word;

	always_comb begin
		word       = in_s.data;
		in_s.ready = !div_busy_q && q_s.ready;
		q_s.valid  = in_s.valid && !div_busy_q;
		accept     = in_s.valid && in_s.ready;
		ld_p       = (ld_pos_q >= size) ? '0 : ld_pos_q;
		em_last    = em_pos_q == size - 1'b1;
		item.cmd   = word.command;
		item.pix   = {word.pixel_red, word.pixel_green, word.pixel_blue};
		if (word.command == CMD_EMIT) begin
			item.pos  = em_pos_q;
			item.col  = em_col_q;
			item.row  = em_row_q;
			item.last = em_last;
		end else begin
			item.pos  = ld_p;
			item.col  = '0;
			item.row  = '0;
			item.last = 1'b0;
		end
		q_s.data = item;
		trial    = {rem_q, dvd_q[POS_W-1]};
		ge       = trial >= {1'b0, width};
		rem_n    = ge ? DIM_W'(trial - {1'b0, width}) : trial[DIM_W-1:0];
		quo_n    = {dvd_q[POS_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_pos_q   <= '0;
			em_pos_q   <= '0;
			em_col_q   <= '0;
			em_row_q   <= '0;
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
		end else if (restart) begin
			div_busy_q <= 1'b1;
			cnt_q      <= '0;
		end else if (div_busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(POS_W - 1)) begin
				div_busy_q <= 1'b0;
				if (quo_n >= POS_W'(height)) begin
					em_pos_q <= '0;
					em_col_q <= '0;
					em_row_q <= '0;
				end else begin
					em_col_q <= rem_n;
					em_row_q <= quo_n[DIM_W-1:0];
				end
			end
		end else if (accept) begin
			if (word.command == CMD_EMIT) begin
				if (em_last) begin
					em_pos_q <= '0;
					em_col_q <= '0;
					em_row_q <= '0;
				end else begin
					em_pos_q <= em_pos_q + 1'b1;
					if (em_col_q == width - 1'b1) begin
						em_col_q <= '0;
						em_row_q <= em_row_q + 1'b1;
					end else begin
						em_col_q <= em_col_q + 1'b1;
					end
				end
			end else begin
				ld_pos_q <= (ld_p + 1'b1 >= size) ? '0 : ld_p + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			dvd_q <= em_pos_q;
			rem_q <= '0;
		end else if (div_busy_q) begin
			dvd_q <= quo_n;
			rem_q <= rem_n;
		end
	end

endmodule

// ===== hdl/awn_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on awn_pkg and awn_stream_if.
module awn_queue (
	input  logic         clk,
	input  logic         arst_n,
	awn_stream_if.sink   push_s,
	awn_stream_if.source pop_s
);
	import awn_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	q_item_t          mem_q [QUEUE_DEPTH];
	logic [IDX_W-1:0] wr_q, rd_q;
	logic [IDX_W:0]   cnt_q;
	logic             push, pop;

	always_comb begin
		push_s.ready = cnt_q < (IDX_W+1)'(QUEUE_DEPTH);
		pop_s.valid  = cnt_q != '0;
		pop_s.data   = mem_q[rd_q];
		push         = push_s.valid && push_s.ready;
		pop          = pop_s.valid && pop_s.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (IDX_W+1)'(push) - (IDX_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_s.data;
	end

endmodule

// ===== hdl/awn_back.sv =====
// Back end: six-stage coordinate pipeline, frame store and output register.
// Depends on awn_pkg and awn_stream_if; inverse coefficients from awn_inverse.
module awn_back #(
	parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	awn_stream_if.sink                  q_s,
	awn_stream_if.source                out_s,
	input  logic [awn_pkg::DIM_W-1:0]   width,
	input  logic [awn_pkg::DIM_W-1:0]   height,
	input  logic [awn_pkg::SHIFT_W-1:0] shift_x,
	input  logic [awn_pkg::SHIFT_W-1:0] shift_y,
	input  awn_pkg::inv_stat_t          inv_stat,
	output awn_pkg::inv_ctrl_t          inv_ctrl
);
	import awn_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = 50;

	function automatic logic [DIM_W:0] fit(input logic [SUM_W-1:0] s,
		input logic [DIM_W-1:0] lim);
		logic             neg;
		logic [SUM_W-1:0] mag, mr;
		logic [29:0]      r;
		neg = s[SUM_W-1];
		mag = neg ? -s : s;
		mr  = mag + SUM_W'(524288);
		r   = mr[SUM_W-1:20];
		return {(r < 30'(lim)) && (!neg || r == '0), r[DIM_W-1:0]};
	endfunction

	logic [PIX_W-1:0] mem [DEPTH];

	logic             stall, head_emit;
	logic [15:0]      u_n, v_n, col16, row16;
	logic [DIM_W:0]   fx, fy;
	q_item_t          it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic             sg_s1, sg_s2, sg_s3, sg_s4, sg_s5, sg_s6;
	logic signed [15:0]        u_s1, v_s1d;
	logic signed [INV_W+15:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [SUM_W-1:0]          sx_s3, sy_s3;
	logic [DIM_W-1:0]          rx_s4, ry_s4;
	logic                      map_s4, map_s5, map_s6;
	logic [AW-1:0]             addr_s5;
	logic [PIX_W-1:0]          rdata_s6, pix_o;
	out_word_t                 ow;

	always_comb begin
		stall          = out_s.valid && !out_s.ready;
		head_emit      = q_s.data.cmd == CMD_EMIT;
		q_s.ready      = !stall && (!head_emit || inv_stat.ready);
		inv_ctrl.start = q_s.valid && head_emit && !inv_stat.ready && !inv_stat.busy;
		col16 = 16'(q_s.data.col) - 16'(width >> 1);
		row16 = 16'(q_s.data.row) - 16'(height >> 1);
		u_n   = (col16 << 4) - 16'(signed'(shift_x));
		v_n   = (row16 << 4) - 16'(signed'(shift_y));
		fx    = fit(sx_s3, width);
		fy    = fit(sy_s3, height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= q_s.valid && q_s.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			it_s1  <= q_s.data;
			sg_s1  <= inv_stat.singular;
			u_s1   <= signed'(u_n);
			v_s1d  <= signed'(v_n);
			it_s2  <= it_s1;
			sg_s2  <= sg_s1;
			p00_s2 <= signed'(inv_stat.coef[0]) * u_s1;
			p01_s2 <= signed'(inv_stat.coef[1]) * v_s1d;
			p10_s2 <= signed'(inv_stat.coef[2]) * u_s1;
			p11_s2 <= signed'(inv_stat.coef[3]) * v_s1d;
			it_s3  <= it_s2;
			sg_s3  <= sg_s2;
			sx_s3  <= SUM_W'(p00_s2) + SUM_W'(p01_s2) + {{(SUM_W-DIM_W-19){1'b0}}, width, 19'b0};
			sy_s3  <= SUM_W'(p10_s2) + SUM_W'(p11_s2) + {{(SUM_W-DIM_W-19){1'b0}}, height, 19'b0};
			it_s4  <= it_s3;
			sg_s4  <= sg_s3;
			rx_s4  <= fx[DIM_W-1:0];
			ry_s4  <= fy[DIM_W-1:0];
			map_s4 <= fx[DIM_W] && fy[DIM_W];
			it_s5  <= it_s4;
			sg_s5  <= sg_s4;
			map_s5 <= sg_s4 || map_s4;
			if (sg_s4 || it_s4.cmd == CMD_LOAD) begin
				addr_s5 <= AW'(it_s4.pos);
			end else begin
				addr_s5 <= AW'(POS_W'(ry_s4) * POS_W'(width) + POS_W'(rx_s4));
			end
			it_s6  <= it_s5;
			sg_s6  <= sg_s5;
			map_s6 <= map_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && v_s5) begin
			if (it_s5.cmd == CMD_LOAD) begin
				mem[addr_s5] <= it_s5.pix;
			end else begin
				rdata_s6 <= mem[addr_s5];
			end
		end
	end

	always_comb begin
		pix_o         = map_s6 ? rdata_s6 : '0;
		ow.out_blue   = pix_o[7:0];
		ow.out_green  = pix_o[15:8];
		ow.out_red    = pix_o[23:16];
		ow.out_column = it_s6.col[7:0];
		ow.out_row    = it_s6.row[7:0];
		ow.mapped     = map_s6;
		ow.singular   = sg_s6;
		ow.last       = it_s6.last;
		out_s.valid   = v_s6 && it_s6.cmd == CMD_EMIT;
		out_s.data    = ow;
	end

endmodule

// ===== hdl/affine_warp_nearest_unit.sv =====
// Inverse affine warp, nearest neighbor. Loads retire and emit results are shown once the item
// has passed the back-end pipeline. One word per cycle is sustained in both directions while the
// output is not stalled and neither wait below applies. The first emit after reset or a register
// write waits for the sequential inverse (one multiply, one determinant, four 45-step divisions);
// a register write also holds the input while the raster position is re-divided by the width.
// Reset is asynchronous: control state clears, registers take their reset values, the frame store is undefined.
module affine_warp_nearest_unit #(
	parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	awn_stream_if.sink                   pixel_in,
	awn_stream_if.source                 pixel_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [awn_pkg::APB_AW-1:0]   paddr,
	input  logic [awn_pkg::APB_DW-1:0]   pwdata,
	output logic [awn_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import awn_pkg::*;

	logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [SHIFT_W-1:0]       shift_x_q, shift_y_q;
	logic [DIM_W-1:0]         width_q, height_q, w_eff, h_eff;
	logic [POS_W-1:0]         size;
	logic                     cfg_wr;
	reg_idx_t                 idx;
	inv_ctrl_t                inv_ctrl;
	inv_stat_t                inv_stat;

	awn_stream_if #(.T(q_item_t)) fe_q ();
	awn_stream_if #(.T(q_item_t)) q_be ();

	always_comb begin
		pready = 1'b1;
		idx    = reg_idx_t'(paddr[4:2]);
		cfg_wr = psel && penable && pwrite;
		w_eff  = (width_q == '0) ? DIM_W'(1) :
			(32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
		h_eff  = (height_q == '0) ? DIM_W'(1) :
			(32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;
		size   = POS_W'(w_eff) * POS_W'(h_eff);
		case (idx)
			REG_COEF_A:  prdata = APB_DW'(unsigned'(coef_a_q));
			REG_COEF_B:  prdata = APB_DW'(unsigned'(coef_b_q));
			REG_COEF_C:  prdata = APB_DW'(unsigned'(coef_c_q));
			REG_COEF_D:  prdata = APB_DW'(unsigned'(coef_d_q));
			REG_SHIFT_X: prdata = APB_DW'(shift_x_q);
			REG_SHIFT_Y: prdata = APB_DW'(shift_y_q);
			REG_WIDTH:   prdata = APB_DW'(width_q);
			REG_HEIGHT:  prdata = APB_DW'(height_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= COEF_W'(4096);
			coef_b_q  <= '0;
			coef_c_q  <= '0;
			coef_d_q  <= COEF_W'(4096);
			shift_x_q <= '0;
			shift_y_q <= '0;
			width_q   <= DIM_W'(256);
			height_q  <= DIM_W'(256);
		end else if (cfg_wr) begin
			case (idx)
				REG_COEF_A:  coef_a_q  <= pwdata[COEF_W-1:0];
				REG_COEF_B:  coef_b_q  <= pwdata[COEF_W-1:0];
				REG_COEF_C:  coef_c_q  <= pwdata[COEF_W-1:0];
				REG_COEF_D:  coef_d_q  <= pwdata[COEF_W-1:0];
				REG_SHIFT_X: shift_x_q <= pwdata[SHIFT_W-1:0];
				REG_SHIFT_Y: shift_y_q <= pwdata[SHIFT_W-1:0];
				REG_WIDTH:   width_q   <= pwdata[DIM_W-1:0];
				REG_HEIGHT:  height_q  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	awn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_s    (pixel_in),
		.q_s     (fe_q),
		.width   (w_eff),
		.height  (h_eff),
		.size    (size),
		.restart (cfg_wr)
	);

	awn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_s (fe_q),
		.pop_s  (q_be)
	);

	awn_inverse u_inverse (
		.clk    (clk),
		.arst_n (arst_n),
		.coef_a (coef_a_q),
		.coef_b (coef_b_q),
		.coef_c (coef_c_q),
		.coef_d (coef_d_q),
		.clr    (cfg_wr),
		.ctrl   (inv_ctrl),
		.stat   (inv_stat)
	);

	awn_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_s      (q_be),
		.out_s    (pixel_out),
		.width    (w_eff),
		.height   (h_eff),
		.shift_x  (shift_x_q),
		.shift_y  (shift_y_q),
		.inv_stat (inv_stat),
		.inv_ctrl (inv_ctrl)
	);

endmodule

// ===== hdl/awn_checker.sv =====
// Port-level checks of the affine warp unit, bound to the top level.
// Depends on awn_pkg and affine_warp_nearest_unit.
module awn_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [awn_pkg::APB_AW-1:0] paddr,
	input logic [awn_pkg::APB_DW-1:0] pwdata,
	input logic [awn_pkg::APB_DW-1:0] prdata,
	input logic                       pready,
	input logic                       out_valid,
	input logic                       out_ready,
	input awn_pkg::out_word_t         out_data
);
	import awn_pkg::*;

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |-> out_data.mapped)
		else $error("singular word not mapped");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.mapped |->
		out_data.out_red == '0 && out_data.out_green == '0 && out_data.out_blue == '0)
		else $error("unmapped word not black");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == '0 ##1
		psel && !pwrite && paddr == '0 |-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("register readback mismatch");

endmodule

bind affine_warp_nearest_unit awn_checker u_awn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_data  (pixel_out.data)
);
